/* src/ogglp_pkg.sv */
// shared types and constants of the ogg page lacing parser
package ogglp_pkg;

  // page layout
  localparam logic [8:0] SkipHiPos  = 9'd4;
  localparam logic [8:0] SkipLoPos  = 9'd5;
  localparam logic [8:0] CountPos   = 9'd26;
  localparam logic [8:0] TableStart = 9'd27;
  localparam logic [8:0] PosMax     = 9'd511;

  // a lacing value of this size continues the packet
  localparam logic [7:0] LaceCont = 8'd255;

  // reset value of the frame size register
  localparam logic [15:0] FrameBytesReset = 16'd3840;

  // one result word
  typedef struct packed {
    logic        packet_valid;
    logic [15:0] packet_length;
    logic [15:0] packet_offset;
    logic [7:0]  packet_index;
    logic [15:0] pre_skip;
    logic        partial_tail;
    logic        page_done;
    logic [7:0]  packet_count;
    logic [23:0] decoded_bytes;
  } result_t;

endpackage

/* src/ogg_page_lacing_parser_top.sv */
// top level of the ogg page lacing parser
// Takes one page byte per cycle while in_stall_o is low (page_start_i marks
// byte 0) and walks the segment table: bytes 4 and 5 give a big-endian
// pre-skip, byte 26 the segment count, and the lacing values from byte 27 on
// are joined into packets. Every complete packet gives one word with its
// length, page offset and index; a table ending in 255 gives a partial-tail
// word, and the last word of a table carries the packet count and
// packet_count * frame_bytes. The parse state update handles each accepted
// byte; a word goes into the output register, or into the skid register when
// the output is held. Input is stalled only when both hold words the consumer
// has not taken. The user must write frame_bytes through the cfg port only
// while no page is in flight; the block itself does not enforce this.
module ogg_page_lacing_parser_top
  import ogglp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_frame_bytes_i,
  // input bytes
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        page_start_i,
  // result words
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        packet_valid_o,
  output logic [15:0] packet_length_o,
  output logic [15:0] packet_offset_o,
  output logic [7:0]  packet_index_o,
  output logic [15:0] pre_skip_o,
  output logic        partial_tail_o,
  output logic        page_done_o,
  output logic [7:0]  packet_count_o,
  output logic [23:0] decoded_bytes_o
);

  logic [15:0] frame_bytes_q;
  logic [8:0]  pos_q, pos_d;
  logic [7:0]  seg_total_q, seg_total_d;
  logic [7:0]  seg_seen_q, seg_seen_d;
  logic [15:0] run_len_q, run_len_d;
  logic [15:0] next_off_q, next_off_d;
  logic [7:0]  pkts_q, pkts_d;
  logic [15:0] skip_q, skip_d;
  logic        tbl_done_q, tbl_done_d;

  logic        accept;
  logic        full;
  logic        has_res;
  result_t     res;
  result_t     res_out;

  // per-page values as seen by this word
  logic [8:0]  e_pos;
  logic [7:0]  e_total, e_seen, seen_inc;
  logic [15:0] e_run, run_sum, e_off;
  logic [7:0]  e_pkts, cnt;
  logic [15:0] e_skip;
  logic        active, last, done;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = full;
  assign accept      = in_valid_i && !full;

  // frame size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_bytes_q <= FrameBytesReset;
    end else if (cfg_valid_i) begin
      frame_bytes_q <= cfg_frame_bytes_i;
    end
  end

  // page start clears the page state before the byte is looked at
  always_comb begin
    e_pos   = page_start_i ? '0 : pos_q;
    e_total = page_start_i ? '0 : seg_total_q;
    e_seen  = page_start_i ? '0 : seg_seen_q;
    e_run   = page_start_i ? '0 : run_len_q;
    e_off   = page_start_i ? '0 : next_off_q;
    e_pkts  = page_start_i ? '0 : pkts_q;
    e_skip  = page_start_i ? '0 : skip_q;
    active  = page_start_i || !tbl_done_q;
  end

  assign seen_inc = e_seen + 8'd1;
  assign last     = (seen_inc == e_total);
  assign run_sum  = e_run + {8'd0, data_byte_i};

  // parse step
  always_comb begin
    pos_d      = e_pos;
    seg_total_d = e_total;
    seg_seen_d = e_seen;
    run_len_d  = e_run;
    next_off_d = e_off;
    pkts_d     = e_pkts;
    skip_d     = e_skip;
    tbl_done_d = tbl_done_q;
    has_res    = 1'b0;
    done       = 1'b0;
    cnt        = e_pkts;

    res               = '0;
    res.pre_skip      = e_skip;
    res.packet_offset = e_off;
    res.packet_index  = e_pkts;

    if (active) begin
      tbl_done_d = 1'b0;
      if (e_pos == SkipHiPos) begin
        skip_d         = {data_byte_i, e_skip[7:0]};
      end else if (e_pos == SkipLoPos) begin
        skip_d         = {e_skip[15:8], data_byte_i};
      end else if (e_pos == CountPos) begin
        seg_total_d = data_byte_i;
        next_off_d  = {8'd0, data_byte_i} + {7'd0, TableStart};
        if (data_byte_i == 8'd0) begin
          has_res               = 1'b1;
          done                  = 1'b1;
          tbl_done_d            = 1'b1;
          res.packet_offset     = {7'd0, TableStart};
        end
      end else if (e_pos >= TableStart) begin
        seg_seen_d = seen_inc;
        run_len_d  = run_sum;
        if (data_byte_i != LaceCont) begin
          // packet ends here
          has_res           = 1'b1;
          done              = last;
          cnt               = e_pkts + 8'd1;
          pkts_d            = cnt;
          next_off_d        = e_off + run_sum;
          run_len_d         = '0;
          res.packet_valid  = 1'b1;
          res.packet_length = run_sum;
        end else if (last) begin
          // run continues on the next page
          has_res           = 1'b1;
          done              = 1'b1;
          res.partial_tail  = 1'b1;
          res.packet_length = run_sum;
        end
        if (last) begin
          tbl_done_d = 1'b1;
        end
      end
      if (e_pos != PosMax) begin
        pos_d = e_pos + 9'd1;
      end
    end

    res.page_done     = done;
    res.packet_count  = cnt;
    res.pre_skip      = skip_d;
    res.decoded_bytes = done ? ({16'd0, cnt} * {8'd0, frame_bytes_q}) : '0;
  end

  // parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      seg_total_q <= '0;
      seg_seen_q  <= '0;
      run_len_q   <= '0;
      next_off_q  <= '0;
      pkts_q      <= '0;
      skip_q      <= '0;
      tbl_done_q  <= 1'b1;
    end else if (accept) begin
      pos_q       <= pos_d;
      seg_total_q <= seg_total_d;
      seg_seen_q  <= seg_seen_d;
      run_len_q   <= run_len_d;
      next_off_q  <= next_off_d;
      pkts_q      <= pkts_d;
      skip_q      <= skip_d;
      tbl_done_q  <= tbl_done_d;
    end
  end

  // result buffering
  ogglp_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept && has_res),
    .res_i       (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_out)
  );

  assign packet_valid_o  = res_out.packet_valid;
  assign packet_length_o = res_out.packet_length;
  assign packet_offset_o = res_out.packet_offset;
  assign packet_index_o  = res_out.packet_index;
  assign pre_skip_o      = res_out.pre_skip;
  assign partial_tail_o  = res_out.partial_tail;
  assign page_done_o     = res_out.page_done;
  assign packet_count_o  = res_out.packet_count;
  assign decoded_bytes_o = res_out.decoded_bytes;

endmodule

/* src/ogglp_out_stage.sv */
// output register with a skid register behind it
module ogglp_out_stage
  import ogglp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t res_i,
  output logic    full_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t res_o
);

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    pop;

  assign pop = out_valid_q && !out_stall_i;

  // steer new words into the output or the skid register
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (pop) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_d       = res_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res_i;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

/* bench/testbench.sv */
// self-checking testbench of the ogg page lacing parser
`timescale 1ns / 100ps

module testbench;
  import ogglp_pkg::*;

  localparam int NoCut       = -1;
  localparam int DrainCycles = 16;
  localparam int HoldCycles  = 150;
  localparam int RunLimitNs  = 1_000_000;

  // how the lacing values of a generated page are chosen
  typedef enum int {
    LaceMix,
    LaceAllCont,
    LaceAllZero,
    LaceAllShort,
    LaceEdges
  } lace_style_e;

  // tracks the page parse and holds the words still to arrive
  class lacing_checker;
    logic [15:0] frame_bytes;
    logic [8:0]  byte_pos;
    logic [7:0]  seg_total;
    logic [7:0]  segs_seen;
    logic [15:0] run_len;
    logic [15:0] next_off;
    logic [7:0]  pkts_done;
    logic [15:0] skip_val;
    bit          table_done;
    result_t     expected_words[$];
    int          errors;
    int          words_checked;
    int          page_ends;
    int          tails;

    function new();
      frame_bytes = FrameBytesReset;
      byte_pos    = '0;
      seg_total   = '0;
      segs_seen   = '0;
      run_len     = '0;
      next_off    = '0;
      pkts_done   = '0;
      skip_val    = '0;
      table_done  = 1'b1;
      errors      = 0;
      words_checked = 0;
      page_ends   = 0;
      tails       = 0;
    endfunction

    function void set_frame_bytes(logic [15:0] v);
      frame_bytes = v;
    endfunction

    function int words_waiting();
      return expected_words.size();
    endfunction

    function result_t make_word(logic valid, logic [15:0] len, logic [15:0] off,
                                logic [7:0] idx, logic tail, logic done);
      result_t w;
      w.packet_valid  = valid;
      w.packet_length = len;
      w.packet_offset = off;
      w.packet_index  = idx;
      w.pre_skip      = skip_val;
      w.partial_tail  = tail;
      w.page_done     = done;
      w.packet_count  = pkts_done;
      w.decoded_bytes = done ? 24'(32'(pkts_done) * 32'(frame_bytes)) : 24'd0;
      return w;
    endfunction

    // advance the parse by one accepted byte
    function void take_byte(logic [7:0] b, logic start);
      logic [7:0]  idx;
      logic [15:0] len;
      logic [15:0] off;
      bit          last;
      if (start) begin
        byte_pos   = '0;
        seg_total  = '0;
        segs_seen  = '0;
        run_len    = '0;
        next_off   = '0;
        pkts_done  = '0;
        skip_val   = '0;
        table_done = 1'b0;
      end
      // idle until a page starts
      if (table_done) return;
      if (byte_pos == SkipHiPos) begin
        skip_val[15:8] = b;
      end else if (byte_pos == SkipLoPos) begin
        skip_val[7:0] = b;
      end else if (byte_pos == CountPos) begin
        seg_total = b;
        next_off  = 16'(TableStart) + 16'(b);
        // empty segment table ends the page at once
        if (b == 8'd0) begin
          expected_words.push_back(make_word(1'b0, 16'd0, 16'(TableStart), 8'd0,
                                             1'b0, 1'b1));
          table_done = 1'b1;
        end
      end else if (byte_pos >= TableStart) begin
        segs_seen = segs_seen + 8'd1;
        last      = (segs_seen == seg_total);
        run_len   = run_len + 16'(b);
        if (b != LaceCont) begin
          len       = run_len;
          off       = next_off;
          idx       = pkts_done;
          pkts_done = pkts_done + 8'd1;
          next_off  = next_off + len;
          run_len   = '0;
          expected_words.push_back(make_word(1'b1, len, off, idx, 1'b0, last));
        end else if (last) begin
          // run still open at the end of the table
          expected_words.push_back(make_word(1'b0, run_len, next_off, pkts_done,
                                             1'b1, 1'b1));
        end
        if (last) table_done = 1'b1;
      end
      if (byte_pos != PosMax) byte_pos = byte_pos + 9'd1;
    endfunction

    function string word_text(result_t w);
      return $sformatf("v=%0b len=%0d off=%0d idx=%0d skip=%0d tail=%0b done=%0b cnt=%0d dec=%0d",
                       w.packet_valid, w.packet_length, w.packet_offset, w.packet_index,
                       w.pre_skip, w.partial_tail, w.page_done, w.packet_count,
                       w.decoded_bytes);
    endfunction

    // compare an accepted word with the oldest expected one
    function void check_word(result_t got);
      result_t exp;
      string   diff;
      if (expected_words.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word: %0s", word_text(got));
        return;
      end
      exp = expected_words.pop_front();
      words_checked++;
      if (exp.page_done) page_ends++;
      if (exp.partial_tail) tails++;
      diff = "";
      if (got.packet_valid !== exp.packet_valid) diff = {diff, " packet_valid"};
      if (got.packet_length !== exp.packet_length) diff = {diff, " packet_length"};
      if (got.packet_offset !== exp.packet_offset) diff = {diff, " packet_offset"};
      if (got.packet_index !== exp.packet_index) diff = {diff, " packet_index"};
      if (got.pre_skip !== exp.pre_skip) diff = {diff, " pre_skip"};
      if (got.partial_tail !== exp.partial_tail) diff = {diff, " partial_tail"};
      if (got.page_done !== exp.page_done) diff = {diff, " page_done"};
      if (got.packet_count !== exp.packet_count) diff = {diff, " packet_count"};
      if (got.decoded_bytes !== exp.decoded_bytes) diff = {diff, " decoded_bytes"};
      if (diff != "") begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch in word %0d:%0s", words_checked, diff);
          $display("  expected %0s", word_text(exp));
          $display("  actual   %0s", word_text(got));
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [15:0] cfg_frame_bytes_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic        page_start_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        packet_valid_o;
  logic [15:0] packet_length_o;
  logic [15:0] packet_offset_o;
  logic [7:0]  packet_index_o;
  logic [15:0] pre_skip_o;
  logic        partial_tail_o;
  logic        page_done_o;
  logic [7:0]  packet_count_o;
  logic [23:0] decoded_bytes_o;

  result_t       seen_word;
  lacing_checker sb;
  bit            idle_on;
  int            hold_cycles;
  int            items_sent;
  int            pages_sent;
  int            frame_writes;
  int            total_errors;

  ogg_page_lacing_parser_top uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_frame_bytes_i (cfg_frame_bytes_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .data_byte_i       (data_byte_i),
    .page_start_i      (page_start_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .packet_valid_o    (packet_valid_o),
    .packet_length_o   (packet_length_o),
    .packet_offset_o   (packet_offset_o),
    .packet_index_o    (packet_index_o),
    .pre_skip_o        (pre_skip_o),
    .partial_tail_o    (partial_tail_o),
    .page_done_o       (page_done_o),
    .packet_count_o    (packet_count_o),
    .decoded_bytes_o   (decoded_bytes_o)
  );

  assign seen_word = {packet_valid_o, packet_length_o, packet_offset_o, packet_index_o,
                      pre_skip_o, partial_tail_o, page_done_o, packet_count_o,
                      decoded_bytes_o};

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #(RunLimitNs);
    $display("testbench: done, errors");
    $finish;
  end

  // watch both channels
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) sb.take_byte(data_byte_i, page_start_i);
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_word(seen_word);
  end

  // consumer stall: long hold on request, else random bursts when idle_on is set
  initial begin : out_stall_gen
    int n;
    out_stall_i <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_cycles != 0) begin
        n = hold_cycles;
        hold_cycles = 0;
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end
    end
  end

  // offer one byte, with an occasional gap ahead of it when idle_on is set
  task automatic send_byte(input logic [7:0] b, input logic start);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    data_byte_i  <= b;
    page_start_i <= start;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  function automatic logic [7:0] pick_lace(input lace_style_e style, input int k);
    case (style)
      LaceAllCont:  return LaceCont;
      LaceAllZero:  return 8'd0;
      LaceAllShort: return 8'($urandom_range(0, 254));
      LaceEdges:
        case (k % 3)
          0:       return 8'd0;
          1:       return LaceCont;
          default: return 8'd254;
        endcase
      default:
        case ($urandom_range(0, 5))
          0, 1:    return LaceCont;
          2:       return 8'd0;
          3:       return 8'd254;
          default: return 8'($urandom_range(1, 253));
        endcase
    endcase
  endfunction

  // one page: header, segment table, then ignored payload; cut drops the rest
  task automatic send_page(input int segs, input lace_style_e style, input int cut,
                           input int payload);
    int p;
    pages_sent++;
    for (p = 0; p <= 26 + segs; p++) begin
      if (p == cut) return;
      if (p == 0) send_byte(8'($urandom), 1'b1);
      else if (p == CountPos) send_byte(8'(segs), 1'b0);
      else if (p >= TableStart) send_byte(pick_lace(style, p - TableStart), 1'b0);
      else send_byte(8'($urandom), 1'b0);
    end
    repeat (payload) send_byte(8'($urandom), 1'b0);
  endtask

  // random pages, mostly well formed, some cut short or preceded by stray bytes
  task automatic random_pages(input int goal_items);
    int          goal;
    int          segs;
    int          cut;
    int          roll;
    lace_style_e style;
    goal = items_sent + goal_items;
    while (items_sent < goal) begin
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0);
      end
      roll = $urandom_range(0, 59);
      if (roll == 0) segs = $urandom_range(100, 255);
      else if (roll < 6) segs = 0;
      else segs = $urandom_range(1, 12);
      case ($urandom_range(0, 9))
        7:       style = LaceAllCont;
        8:       style = LaceAllShort;
        9:       style = LaceEdges;
        default: style = LaceMix;
      endcase
      cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 26 + segs) : NoCut;
      send_page(segs, style, cut, $urandom_range(0, 6));
    end
    // leave the parser idle at the end of the phase
    send_page($urandom_range(1, 8), LaceMix, NoCut, 1);
  endtask

  // stop offering and wait for every expected word plus the pipeline
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.words_waiting() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_frame_bytes(input logic [15:0] v);
    cfg_valid_i       <= 1'b1;
    cfg_frame_bytes_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    sb.set_frame_bytes(v);
    frame_writes++;
  endtask

  // main sequence
  initial begin
    sb = new();
    rst_ni            = 1'b0;
    cfg_valid_i       = 1'b0;
    cfg_frame_bytes_i = '0;
    in_valid_i        = 1'b0;
    data_byte_i       = '0;
    page_start_i      = 1'b0;
    idle_on           = 1'b1;
    hold_cycles       = 0;
    items_sent        = 0;
    pages_sent        = 0;
    frame_writes      = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed pages at the reset frame size
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_page(0, LaceMix, NoCut, 0);
    send_page(1, LaceAllCont, NoCut, 1);
    send_page(5, LaceEdges, NoCut, 0);
    send_page(4, LaceEdges, NoCut, 2);
    send_page(6, LaceMix, 28, 0);
    send_page(3, LaceMix, 5, 0);
    send_page(2, LaceMix, NoCut, 0);
    drain();

    // largest tables at the largest frame size
    write_frame_bytes(16'hFFFF);
    send_page(255, LaceAllZero, NoCut, 0);
    send_page(255, LaceAllCont, NoCut, 0);

    // consumer holds off while a busy page streams in
    idle_on = 1'b0;
    hold_cycles = HoldCycles;
    send_page(40, LaceAllShort, NoCut, 0);
    idle_on = 1'b1;
    random_pages(30);
    drain();

    write_frame_bytes(16'd0);
    random_pages(30);
    drain();

    write_frame_bytes(16'd960);
    random_pages(30);
    drain();

    // last part runs without idling
    write_frame_bytes(16'($urandom_range(1, 65534)));
    idle_on = 1'b0;
    random_pages(30);
    drain();

    total_errors = sb.errors + sb.words_waiting();
    $display("summary: %0d bytes over %0d pages, %0d words checked", items_sent,
             pages_sent, sb.words_checked);
    $display("summary: %0d page ends, %0d partial tails, %0d frame size writes, %0d errors",
             sb.page_ends, sb.tails, frame_writes, total_errors);
    if (total_errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
